[rtl/mmf_pkg.sv]
// Shared types and constants for the 3x3 min/max filter.
`timescale 1ns / 1ps
`default_nettype none

package mmf_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int PIX_W = 8;
    localparam int ROW_W = 16;
    localparam int CFG_W = 16;
    localparam int IMG_WIDTH_W = 11;

    localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]       IMG_HEIGHT_RESET = 16'd480;

    // Register indexes on the configuration port
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // Result queue depth, a power of two
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Results caused by one item, at most three
    localparam int MAX_RESULTS = 3;
    localparam int NRES_W = 2;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic             res_main;    // filtered or border result for (c-1, r-1)
        logic             interior;    // (c-1, r-1) is an interior pixel
        logic             res_right;   // right-border result for (c, r-1)
        logic             res_bottom;  // last-row pass-through for (c, r)
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
    } item_ctrl_t;

    // One result without its column
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] min_value;
        logic [PIX_W-1:0] max_value;
        logic             last;
    } result_t;

endpackage : mmf_pkg

`default_nettype wire

[rtl/mmf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : mmf_ram

`default_nettype wire

[rtl/mmf_window.sv]
// 3x3 window registers, min/max reduction and result formation.
`timescale 1ns / 1ps
`default_nettype none

module mmf_window #(
    parameter int COL_W = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s1_valid,
    input  wire mmf_pkg::item_ctrl_t        s1_ctrl,
    input  wire logic [COL_W-1:0]           s1_col,
    input  wire logic [mmf_pkg::PIX_W-1:0]  rd_a,
    input  wire logic [mmf_pkg::PIX_W-1:0]  rd_b,
    output logic      [mmf_pkg::NRES_W-1:0] push_count,
    output logic      [COL_W+$bits(mmf_pkg::result_t)-1:0] push_data [mmf_pkg::MAX_RESULTS]
);

    import mmf_pkg::*;

    localparam int ENTRY_W = COL_W + $bits(result_t);

    logic [PIX_W-1:0] win_reg [9];
    logic             s2_valid_reg;
    item_ctrl_t       s2_ctrl_reg;
    logic [COL_W-1:0] s2_col_reg;

    logic [PIX_W-1:0]  lo;
    logic [PIX_W-1:0]  hi;
    result_t           res_main;
    result_t           res_right;
    result_t           res_bottom;
    logic [NRES_W-1:0] slot;

    // Shift the window one column and load the new column from the line stores and the pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            if (s1_valid)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= rd_b;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= rd_a;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s1_ctrl.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            s2_ctrl_reg <= s1_ctrl;
            s2_col_reg  <= s1_col;
        end
    end

    always_comb
    begin
        lo = win_reg[4];
        hi = win_reg[4];
        if (s2_ctrl_reg.interior)
        begin
            for (int i = 0; i < 9; i++)
            begin
                if (win_reg[i] < lo)
                begin
                    lo = win_reg[i];
                end
                if (win_reg[i] > hi)
                begin
                    hi = win_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        res_main.row       = s2_ctrl_reg.row - ROW_W'(1);
        res_main.min_value = lo;
        res_main.max_value = hi;
        res_main.last      = !s2_ctrl_reg.res_right && !s2_ctrl_reg.res_bottom;

        res_right.row       = s2_ctrl_reg.row - ROW_W'(1);
        res_right.min_value = win_reg[5];
        res_right.max_value = win_reg[5];
        res_right.last      = !s2_ctrl_reg.res_bottom;

        res_bottom.row       = s2_ctrl_reg.row;
        res_bottom.min_value = s2_ctrl_reg.pixel;
        res_bottom.max_value = s2_ctrl_reg.pixel;
        res_bottom.last      = 1'b1;
    end

    // Pack the present results into consecutive slots in raster order
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            push_data[i] = '0;
        end
        slot = '0;
        if (s2_ctrl_reg.res_main)
        begin
            push_data[slot] = ENTRY_W'({s2_col_reg - COL_W'(1), res_main});
            slot = slot + NRES_W'(1);
        end
        if (s2_ctrl_reg.res_right)
        begin
            push_data[slot] = ENTRY_W'({s2_col_reg, res_right});
            slot = slot + NRES_W'(1);
        end
        if (s2_ctrl_reg.res_bottom)
        begin
            push_data[slot] = ENTRY_W'({s2_col_reg, res_bottom});
            slot = slot + NRES_W'(1);
        end
        push_count = s2_valid_reg ? slot : '0;
    end

endmodule : mmf_window

`default_nettype wire

[rtl/mmf_fifo.sv]
// Result queue: takes up to three entries per cycle, gives one.
`timescale 1ns / 1ps
`default_nettype none

module mmf_fifo #(
    parameter int WIDTH = 43
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [mmf_pkg::NRES_W-1:0]     push_count,
    input  wire logic [WIDTH-1:0]               push_data [mmf_pkg::MAX_RESULTS],
    input  wire logic                           pop,
    output logic      [WIDTH-1:0]               head,
    output logic      [mmf_pkg::FIFO_CNT_W-1:0] count
);

    import mmf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [WIDTH-1:0]      mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (NRES_W'(i) < push_count)
            begin
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule : mmf_fifo

`default_nettype wire

[rtl/min_max_filter_3x3.sv]
// Top level of the 3x3 min/max filter: counters, line stores, queue control.
`timescale 1ns / 1ps
`default_nettype none

// 3x3 min/max filter on a raster stream of 8-bit gray pixels. Takes one pixel
// per clock and gives, for each pixel of the frame, the minimum and maximum of
// its 3x3 neighborhood, tagged with its column and row; pixels on the first and
// last row and column pass through unchanged as both values. Row r comes out
// while row r+1 goes in, and the last row comes out as it arrives, so one item
// causes zero to three results; last_of_run marks the final one. The two
// previous rows live in two line-store RAMs of MAX_WIDTH entries, read at the
// pixel's column on acceptance and written back in the next cycle; consecutive
// pixels never touch the same column (width is at least 3), so no forwarding
// is needed. Results pass the stage-1 registers, the window registers and the
// result queue on their way out. The sustained rate is one item per clock
// while out_ready is high; on the last row it is bounded by the single output
// port at one result per clock, and one such item causes one to three results.
// Input is held off only when the 8-entry result queue cannot take every result
// of the items in flight and of the new pixel. The line stores need no clearing
// pass after reset. Width saturates to 3..MAX_WIDTH, height to at least 3;
// write the size registers only while the block is idle.
module min_max_filter_3x3 #(
    parameter int MAX_WIDTH = mmf_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_write,
    input  wire mmf_pkg::reg_index_t        cfg_index,
    input  wire logic [mmf_pkg::CFG_W-1:0]  cfg_data,
    // pixel input
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [mmf_pkg::PIX_W-1:0]  pixel,
    // result output
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [$clog2(MAX_WIDTH)-1:0] out_col,
    output logic      [mmf_pkg::ROW_W-1:0]  out_row,
    output logic      [mmf_pkg::PIX_W-1:0]  min_value,
    output logic      [mmf_pkg::PIX_W-1:0]  max_value,
    output logic                            last_of_run
);

    import mmf_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ENTRY_W = COL_W + $bits(result_t);
    localparam int PEND_W  = FIFO_CNT_W + 2;

    // Configuration registers
    logic [IMG_WIDTH_W-1:0] image_width_reg;
    logic [ROW_W-1:0]       image_height_reg;

    // Position of the next pixel
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;

    // Stage 1: item whose line-store read is in flight
    logic             s1_valid_reg;
    item_ctrl_t       s1_ctrl_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [NRES_W-1:0] s1_nres_reg;

    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    item_ctrl_t        new_ctrl;
    logic [NRES_W-1:0] new_nres;
    logic [PEND_W-1:0] pending;
    logic              accept;

    logic [PIX_W-1:0]      rd_a;
    logic [PIX_W-1:0]      rd_b;
    logic [NRES_W-1:0]     push_count;
    logic [ENTRY_W-1:0]    push_data [MAX_RESULTS];
    logic [ENTRY_W-1:0]    head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    result_t               head_res;

    // Take register writes; the index is a full decode of the two registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_WIDTH_RESET;
            image_height_reg <= IMG_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[ROW_W-1:0];
                default:          image_height_reg <= image_height_reg;
            endcase
        end
    end

    // Saturate the frame size to the supported range, as last column/row index
    always_comb
    begin
        if (32'(image_width_reg) > MAX_WIDTH)
        begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end
        else if (image_width_reg < IMG_WIDTH_W'(3))
        begin
            w_last = COL_W'(2);
        end
        else
        begin
            w_last = COL_W'(image_width_reg - IMG_WIDTH_W'(1));
        end

        if (image_height_reg < ROW_W'(3))
        begin
            h_last = ROW_W'(2);
        end
        else
        begin
            h_last = image_height_reg - ROW_W'(1);
        end
    end

    // Clamp the position to the current size and work out which results come
    always_comb
    begin
        c = (col_count_reg < w_last) ? col_count_reg : w_last;
        r = (row_count_reg < h_last) ? row_count_reg : h_last;

        new_ctrl.res_main   = (r != '0) && (c != '0);
        new_ctrl.interior   = (r >= ROW_W'(2)) && (c >= COL_W'(2));
        new_ctrl.res_right  = (r != '0) && (c == w_last);
        new_ctrl.res_bottom = (r == h_last);
        new_ctrl.pixel      = pixel;
        new_ctrl.row        = r;

        new_nres = NRES_W'(new_ctrl.res_main) + NRES_W'(new_ctrl.res_right)
                 + NRES_W'(new_ctrl.res_bottom);
    end

    // Reserve queue room for every result of the items already in flight
    always_comb
    begin
        pending = PEND_W'(fifo_count)
                + PEND_W'(s1_valid_reg ? s1_nres_reg : NRES_W'(0))
                + PEND_W'(push_count);
        in_ready = (pending + PEND_W'(new_nres)) <= PEND_W'(FIFO_DEPTH);
    end

    assign accept = in_valid && in_ready;

    // Advance the position on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (c == w_last)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= (r == h_last) ? '0 : r + ROW_W'(1);
                end
                else
                begin
                    col_count_reg <= c + COL_W'(1);
                    row_count_reg <= r;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= new_ctrl;
            s1_col_reg  <= c;
            s1_nres_reg <= new_nres;
        end
    end

    // Line store A holds the previous row, B the row before it.
    // Read at acceptance, write back in the next cycle: A <= pixel, B <= old A.
    mmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_ctrl_reg.pixel),
        .re    (accept),
        .raddr (c),
        .rdata (rd_a)
    );

    mmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (rd_a),
        .re    (accept),
        .raddr (c),
        .rdata (rd_b)
    );

    mmf_window #(
        .COL_W (COL_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_ctrl    (s1_ctrl_reg),
        .s1_col     (s1_col_reg),
        .rd_a       (rd_a),
        .rd_b       (rd_b),
        .push_count (push_count),
        .push_data  (push_data)
    );

    mmf_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (push_data),
        .pop        (out_valid && out_ready),
        .head       (head),
        .count      (fifo_count)
    );

    // Drive the result port from the queue head
    assign head_res    = head[$bits(result_t)-1:0];
    assign out_valid   = (fifo_count != '0);
    assign out_col     = head[ENTRY_W-1:$bits(result_t)];
    assign out_row     = head_res.row;
    assign min_value   = head_res.min_value;
    assign max_value   = head_res.max_value;
    assign last_of_run = head_res.last;

endmodule : min_max_filter_3x3

`default_nettype wire
